// ----- design/sdcas_pkg.sv -----
// Shared types and codes for the SD card access sequencer.
// No dependencies; every module of the block imports this package.
`default_nettype none

package sdcas_pkg;

    // Request codes carried by the op field
    localparam logic [2:0] OP_POLL  = 3'd0;
    localparam logic [2:0] OP_INIT  = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_MULTI = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // Status answers
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PENDING = 2'd1;
    localparam logic [1:0] ST_BUSY    = 2'd2;
    localparam logic [1:0] ST_FAIL    = 2'd3;

    // Completion events
    localparam logic [2:0] EV_NONE       = 3'd0;
    localparam logic [2:0] EV_WRITE_DONE = 3'd1;
    localparam logic [2:0] EV_READ_DONE  = 3'd2;
    localparam logic [2:0] EV_WRITE_FAIL = 3'd3;
    localparam logic [2:0] EV_READ_FAIL  = 3'd4;

    // Host commands
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Card type codes from the host
    localparam logic [1:0] CTYPE_V1 = 2'd0;
    localparam logic [1:0] CTYPE_HC = 2'd2;

    // Card version codes
    localparam logic [1:0] VER_ONE = 2'd1;
    localparam logic [1:0] VER_TWO = 2'd2;

    // Block size as a shift: 512 bytes per block
    localparam int BLOCK_SHIFT = 9;

    // Failure counter saturates here
    localparam logic [3:0] FAIL_CNT_MAX = 4'd15;

    // Configuration register map
    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_INIT_TO  = 2'd0;
    localparam logic [1:0] REG_READ_TO  = 2'd1;
    localparam logic [1:0] REG_WRITE_TO = 2'd2;
    localparam logic [1:0] REG_MAX_FAIL = 2'd3;

    // Register reset values
    localparam logic [15:0] INIT_TO_RST  = 16'd200;
    localparam logic [15:0] READ_TO_RST  = 16'd100;
    localparam logic [15:0] WRITE_TO_RST = 16'd250;
    localparam logic [3:0]  MAX_FAIL_RST = 4'd8;

    // Sequencer states
    typedef enum logic [3:0] {
        CS_NOT_PRESENT = 4'd0,
        CS_RESET       = 4'd1,
        CS_INIT        = 4'd2,
        CS_RECV_ID     = 4'd3,
        CS_READY       = 4'd4,
        CS_READING     = 4'd5,
        CS_SEND_WRITE  = 4'd6,
        CS_WAIT_WRITE  = 4'd7,
        CS_MULTI_WRITE = 4'd8,
        CS_STOP_MULTI  = 4'd9
    } t_seq_state;

    typedef struct packed {
        logic [15:0] init_to;
        logic [15:0] read_to;
        logic [15:0] write_to;
        logic [3:0]  max_fail;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] block_index;
        logic [31:0] block_count;
        logic [31:0] now_ms;
        logic        card_present;
        logic        host_init_ok;
        logic        transfer_ok;
        logic        write_sent;
        logic        read_pending;
        logic        cmd_accepted;
        logic [1:0]  card_type;
        logic [31:0] request_tag;
    } t_item;

    typedef struct packed {
        logic [1:0]  op_status;
        logic        ready_res;
        logic [2:0]  done_event;
        logic [31:0] done_block;
        logic [31:0] done_tag;
        logic [1:0]  cmd_kind;
        logic [31:0] cmd_byte_address;
        logic        host_reinit;
        logic [1:0]  card_version;
        logic        high_capacity;
        logic [3:0]  card_state;
    } t_result;

endpackage

`default_nettype wire

// ----- design/sdcas_cfg.sv -----
// APB-style configuration registers: timeouts and failure limit.
// Depends on sdcas_pkg for the register map and reset values.
`default_nettype none

module sdcas_cfg import sdcas_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    logic [15:0] r_init_to;
    logic [15:0] r_read_to;
    logic [15:0] r_write_to;
    logic [3:0]  r_max_fail;
    logic [1:0]  w_idx;
    logic        w_wr;

    assign w_idx  = paddr[PADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    // Write on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_to  <= INIT_TO_RST;
            r_read_to  <= READ_TO_RST;
            r_write_to <= WRITE_TO_RST;
            r_max_fail <= MAX_FAIL_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_INIT_TO:  r_init_to  <= pwdata[15:0];
                REG_READ_TO:  r_read_to  <= pwdata[15:0];
                REG_WRITE_TO: r_write_to <= pwdata[15:0];
                REG_MAX_FAIL: r_max_fail <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (w_idx)
            REG_INIT_TO:  prdata = {16'd0, r_init_to};
            REG_READ_TO:  prdata = {16'd0, r_read_to};
            REG_WRITE_TO: prdata = {16'd0, r_write_to};
            REG_MAX_FAIL: prdata = {28'd0, r_max_fail};
            default:      prdata = 32'd0;
        endcase
    end

    assign o_cfg = '{init_to: r_init_to, read_to: r_read_to,
                     write_to: r_write_to, max_fail: r_max_fail};

    a_max_fail_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && w_idx == REG_MAX_FAIL) |=> (r_max_fail == $past(pwdata[3:0])))
        else $error("max_fail register did not take the written value");

endmodule

`default_nettype wire

// ----- design/sdcas_seq.sv -----
// Card sequencer state and the combinational update for one item.
// Depends on sdcas_pkg; driven by the pipeline in the top level.
`default_nettype none

module sdcas_seq import sdcas_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_fire,
    input  wire t_item   i_item,
    input  wire t_cfg    i_cfg,
    output t_result      o_res
);

    typedef struct packed {
        logic [3:0] fail_cnt;
        t_seq_state state;
    } t_fail_upd;

    t_seq_state  r_state,      n_state;
    logic [3:0]  r_fail_cnt,   n_fail_cnt;
    logic [31:0] r_op_start,   n_op_start;
    logic [31:0] r_chain_next, n_chain_next;
    logic [31:0] r_chain_rem,  n_chain_rem;
    logic [31:0] r_pend_blk,   n_pend_blk;
    logic [31:0] r_pend_tag,   n_pend_tag;
    logic [2:0]  r_ver_flags,  n_ver_flags;
    t_result     w_res;

    // Failure reset: bump the count, drop the card at the limit or when absent
    function automatic t_fail_upd fail_step(input logic [3:0] cnt,
                                            input logic [3:0] limit,
                                            input logic       present);
        t_fail_upd u;
        u.fail_cnt = (cnt == FAIL_CNT_MAX) ? cnt : cnt + 4'd1;
        u.state    = (u.fail_cnt >= limit || !present) ? CS_NOT_PRESENT : CS_RESET;
        return u;
    endfunction

    // Wrapping elapsed-time compare
    function automatic logic timed_out(input logic [31:0] now,
                                       input logic [31:0] start,
                                       input logic [15:0] limit);
        logic [31:0] elapsed;
        elapsed = now - start;
        return elapsed > {16'd0, limit};
    endfunction

    // Hold state between items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= CS_NOT_PRESENT;
            r_fail_cnt   <= 4'd0;
            r_op_start   <= 32'd0;
            r_chain_next <= 32'd0;
            r_chain_rem  <= 32'd0;
            r_pend_blk   <= 32'd0;
            r_pend_tag   <= 32'd0;
            r_ver_flags  <= 3'd0;
        end else if (i_fire) begin
            r_state      <= n_state;
            r_fail_cnt   <= n_fail_cnt;
            r_op_start   <= n_op_start;
            r_chain_next <= n_chain_next;
            r_chain_rem  <= n_chain_rem;
            r_pend_blk   <= n_pend_blk;
            r_pend_tag   <= n_pend_tag;
            r_ver_flags  <= n_ver_flags;
        end
    end

    // Next state and result for the item in the input register
    always_comb begin
        t_fail_upd fu;
        logic      xok;
        logic [31:0] now;
        fu           = '{fail_cnt: 4'd0, state: CS_NOT_PRESENT};
        xok          = i_item.transfer_ok;
        now          = i_item.now_ms;
        n_state      = r_state;
        n_fail_cnt   = r_fail_cnt;
        n_op_start   = r_op_start;
        n_chain_next = r_chain_next;
        n_chain_rem  = r_chain_rem;
        n_pend_blk   = r_pend_blk;
        n_pend_tag   = r_pend_tag;
        n_ver_flags  = r_ver_flags;
        w_res        = '0;

        unique case (i_item.op)
            OP_POLL: begin
                // advance the waiting states
                unique case (r_state)
                    CS_SEND_WRITE: begin
                        if (i_item.write_sent) begin
                            n_state          = CS_WAIT_WRITE;
                            n_op_start       = now;
                            w_res.done_event = EV_WRITE_DONE;
                            w_res.done_block = n_pend_blk;
                            w_res.done_tag   = n_pend_tag;
                        end
                    end
                    CS_WAIT_WRITE: begin
                        if (xok) begin
                            n_fail_cnt = 4'd0;
                            if (r_chain_rem > 32'd1) begin
                                n_chain_rem  = r_chain_rem - 32'd1;
                                n_chain_next = r_chain_next + 32'd1;
                                n_state      = CS_MULTI_WRITE;
                            end else begin
                                n_chain_rem = 32'd0;
                                n_state     = CS_READY;
                            end
                        end else if (timed_out(now, r_op_start, i_cfg.write_to)) begin
                            fu = fail_step(n_fail_cnt, i_cfg.max_fail, i_item.card_present);
                            n_fail_cnt = fu.fail_cnt;
                            n_state    = fu.state;
                            if (fu.state == CS_RESET) n_op_start = now;
                            w_res.host_reinit = 1'b1;
                        end
                    end
                    CS_READING: begin
                        if (!i_item.read_pending && xok) begin
                            n_state          = CS_READY;
                            n_fail_cnt       = 4'd0;
                            w_res.done_event = EV_READ_DONE;
                            w_res.done_block = n_pend_blk;
                            w_res.done_tag   = n_pend_tag;
                        end else if (!i_item.read_pending ||
                                     timed_out(now, r_op_start, i_cfg.read_to)) begin
                            fu = fail_step(n_fail_cnt, i_cfg.max_fail, i_item.card_present);
                            n_fail_cnt = fu.fail_cnt;
                            n_state    = fu.state;
                            if (fu.state == CS_RESET) n_op_start = now;
                            w_res.host_reinit = 1'b1;
                            w_res.done_event  = EV_READ_FAIL;
                            w_res.done_block  = n_pend_blk;
                            w_res.done_tag    = n_pend_tag;
                        end
                    end
                    CS_STOP_MULTI: begin
                        if (xok) begin
                            n_state = CS_READY;
                        end else if (timed_out(now, r_op_start, i_cfg.write_to)) begin
                            fu = fail_step(n_fail_cnt, i_cfg.max_fail, i_item.card_present);
                            n_fail_cnt = fu.fail_cnt;
                            n_state    = fu.state;
                            if (fu.state == CS_RESET) n_op_start = now;
                            w_res.host_reinit = 1'b1;
                        end
                    end
                    default: ;
                endcase
                // run through reset and init when nothing is to wait for
                if (n_state == CS_RESET) n_state = CS_INIT;
                if (n_state == CS_INIT && xok) begin
                    n_ver_flags = {i_item.card_type == CTYPE_HC,
                                   (i_item.card_type == CTYPE_V1) ? VER_ONE : VER_TWO};
                    n_chain_rem = 32'd0;
                    n_state     = CS_READY;
                end
                // init timeout
                if ((n_state == CS_RESET || n_state == CS_INIT || n_state == CS_RECV_ID) &&
                    timed_out(now, n_op_start, i_cfg.init_to)) begin
                    fu = fail_step(n_fail_cnt, i_cfg.max_fail, i_item.card_present);
                    n_fail_cnt = fu.fail_cnt;
                    n_state    = fu.state;
                    if (fu.state == CS_RESET) n_op_start = now;
                    w_res.host_reinit = 1'b1;
                end
                w_res.op_status = (n_state == CS_READY || n_state == CS_MULTI_WRITE) ?
                                  ST_OK : ST_BUSY;
            end
            OP_INIT: begin
                if (i_item.card_present && i_item.host_init_ok) begin
                    n_op_start      = now;
                    n_state         = CS_RESET;
                    n_fail_cnt      = 4'd0;
                    w_res.op_status = ST_OK;
                end else begin
                    n_state         = CS_NOT_PRESENT;
                    n_fail_cnt      = (r_fail_cnt == FAIL_CNT_MAX) ?
                                      r_fail_cnt : r_fail_cnt + 4'd1;
                    w_res.op_status = ST_FAIL;
                end
            end
            OP_WRITE: begin
                // a block off the chain ends the chain first
                if (r_state == CS_MULTI_WRITE && i_item.block_index != r_chain_next) begin
                    n_chain_rem = 32'd0;
                    if (xok) begin
                        n_state = CS_READY;
                    end else begin
                        n_state    = CS_STOP_MULTI;
                        n_op_start = now;
                    end
                end
                if (n_state != CS_READY && n_state != CS_MULTI_WRITE) begin
                    w_res.op_status = ST_BUSY;
                end else begin
                    n_pend_blk             = i_item.block_index;
                    n_pend_tag             = i_item.request_tag;
                    n_state                = CS_SEND_WRITE;
                    w_res.cmd_kind         = CMD_WRITE;
                    w_res.cmd_byte_address = i_item.block_index << BLOCK_SHIFT;
                    if (!i_item.cmd_accepted) begin
                        fu = fail_step(n_fail_cnt, i_cfg.max_fail, i_item.card_present);
                        n_fail_cnt = fu.fail_cnt;
                        n_state    = fu.state;
                        if (fu.state == CS_RESET) n_op_start = now;
                        w_res.host_reinit = 1'b1;
                        w_res.done_event  = EV_WRITE_FAIL;
                        w_res.done_block  = n_pend_blk;
                        w_res.done_tag    = n_pend_tag;
                        w_res.op_status   = ST_FAIL;
                    end else begin
                        w_res.op_status = ST_PENDING;
                    end
                end
            end
            OP_MULTI: begin
                if (r_state == CS_MULTI_WRITE && i_item.block_index == r_chain_next) begin
                    w_res.op_status = ST_OK;
                end else begin
                    if (r_state == CS_MULTI_WRITE) begin
                        n_chain_rem = 32'd0;
                        if (xok) begin
                            n_state = CS_READY;
                        end else begin
                            n_state    = CS_STOP_MULTI;
                            n_op_start = now;
                        end
                    end
                    if (n_state != CS_READY) begin
                        w_res.op_status = ST_BUSY;
                    end else begin
                        n_state         = CS_MULTI_WRITE;
                        n_chain_rem     = i_item.block_count;
                        n_chain_next    = i_item.block_index;
                        w_res.op_status = ST_OK;
                    end
                end
            end
            OP_READ: begin
                if (r_state != CS_READY) begin
                    w_res.op_status = ST_BUSY;
                end else begin
                    w_res.cmd_kind         = CMD_READ;
                    w_res.cmd_byte_address = i_item.block_index << BLOCK_SHIFT;
                    if (i_item.cmd_accepted) begin
                        n_pend_blk      = i_item.block_index;
                        n_pend_tag      = i_item.request_tag;
                        n_state         = CS_READING;
                        n_op_start      = now;
                        w_res.op_status = ST_OK;
                    end else begin
                        fu = fail_step(n_fail_cnt, i_cfg.max_fail, i_item.card_present);
                        n_fail_cnt = fu.fail_cnt;
                        n_state    = fu.state;
                        if (fu.state == CS_RESET) n_op_start = now;
                        w_res.host_reinit = 1'b1;
                        w_res.done_event  = EV_READ_FAIL;
                        w_res.done_block  = r_pend_blk;
                        w_res.done_tag    = r_pend_tag;
                        w_res.op_status   = ST_BUSY;
                    end
                end
            end
            default: w_res.op_status = ST_BUSY;
        endcase

        w_res.ready_res     = (n_state == CS_READY || n_state == CS_MULTI_WRITE);
        w_res.card_version  = n_ver_flags[1:0];
        w_res.high_capacity = n_ver_flags[2];
        w_res.card_state    = n_state;
    end

    assign o_res = w_res;

    a_init_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.op == OP_INIT && i_item.card_present && i_item.host_init_ok)
        |=> (r_state == CS_RESET && r_fail_cnt == 4'd0))
        else $error("accepted init did not restart the card");

    a_read_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.op == OP_READ && r_state != CS_READY)
        |-> (w_res.cmd_kind == CMD_NONE && w_res.op_status == ST_BUSY))
        else $error("read command issued while card not ready");

    a_absent_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.op == OP_POLL && r_state == CS_NOT_PRESENT)
        |=> (r_state == CS_NOT_PRESENT))
        else $error("poll moved an absent card");

endmodule

`default_nettype wire

// ----- design/sd_card_access_sequencer.sv -----
// SD card access sequencer: an item passes through the input register, then the result
// register; one item per cycle sustained while i_stall is low.
// The result register parts the two sides, so a new item is taken while a result waits.
// The card state update sits between these two registers.
// Synchronous active-low reset: card not present, counters and chain cleared,
// configuration registers at their defaults, both pipeline stages empty.
`default_nettype none

module sd_card_access_sequencer import sdcas_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input items
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [2:0]         i_op,
    input  wire logic [31:0]        i_block_index,
    input  wire logic [31:0]        i_block_count,
    input  wire logic [31:0]        i_now_ms,
    input  wire logic               i_card_present,
    input  wire logic               i_host_init_ok,
    input  wire logic               i_transfer_ok,
    input  wire logic               i_write_sent,
    input  wire logic               i_read_pending,
    input  wire logic               i_cmd_accepted,
    input  wire logic [1:0]         i_card_type,
    input  wire logic [31:0]        i_request_tag,
    // result items
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [1:0]              o_op_status,
    output logic                    o_ready_res,
    output logic [2:0]              o_done_event,
    output logic [31:0]             o_done_block,
    output logic [31:0]             o_done_tag,
    output logic [1:0]              o_cmd_kind,
    output logic [31:0]             o_cmd_byte_address,
    output logic                    o_host_reinit,
    output logic [1:0]              o_card_version,
    output logic                    o_high_capacity,
    output logic [3:0]              o_card_state,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_res;
    t_result w_res;
    t_cfg    w_cfg;
    logic    w_fire;
    logic    w_accept;

    sdcas_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sdcas_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // Advance when the result register is free or being drained
    assign w_fire   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall  = r_in_valid && !w_fire;
    assign w_accept = i_valid && !o_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= '{op: i_op, block_index: i_block_index, block_count: i_block_count,
                        now_ms: i_now_ms, card_present: i_card_present,
                        host_init_ok: i_host_init_ok, transfer_ok: i_transfer_ok,
                        write_sent: i_write_sent, read_pending: i_read_pending,
                        cmd_accepted: i_cmd_accepted, card_type: i_card_type,
                        request_tag: i_request_tag};
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= w_res;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_op_status        = r_res.op_status;
    assign o_ready_res        = r_res.ready_res;
    assign o_done_event       = r_res.done_event;
    assign o_done_block       = r_res.done_block;
    assign o_done_tag         = r_res.done_tag;
    assign o_cmd_kind         = r_res.cmd_kind;
    assign o_cmd_byte_address = r_res.cmd_byte_address;
    assign o_host_reinit      = r_res.host_reinit;
    assign o_card_version     = r_res.card_version;
    assign o_high_capacity    = r_res.high_capacity;
    assign o_card_state       = r_res.card_state;

    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without an item in the input register");

endmodule

`default_nettype wire
